>>> design/stn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subzone touch navigator package
// Widths, codes, weight tables, arithmetic helpers and the control store.
// ----------------------------------------------------------------------------
package stn_pkg;

  localparam int MASK_W     = 12;
  localparam int NIB_W      = 4;
  localparam int KIND_W     = 2;
  localparam int POS_W      = 6;
  localparam int DIR_W      = 3;
  localparam int EDGE_W     = 5;
  localparam int DZ_W       = 4;
  localparam int D_W        = 5;
  localparam int V_W        = 7;
  localparam int NORM_W     = 4;
  localparam int WGT_W      = 3;
  localparam int PC_W       = 5;
  localparam int COND_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int DNUM_W     = 7;
  localparam int DDEN_W     = 6;
  localparam int DIV_STEPS  = DNUM_W;
  localparam int DCNT_W     = 3;

  localparam int GRAV_SCALE = 10;
  localparam int X_DIV      = 3;
  localparam int SP_SCALE   = 8 * 3;
  localparam int SP_RECIP   = 205;
  localparam int SP_SHIFT   = 11;
  localparam int SP_PROD_W  = 17;

  localparam logic [CFG_IDX_W-1:0] REG_NAV_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE_Y = 3'd4;

  localparam logic              EN_RESET     = 1'b1;
  localparam logic [MASK_W-1:0] CORNER_RESET = 12'h666;
  localparam logic [EDGE_W-1:0] EDGE_RESET   = 5'd30;
  localparam logic [DZ_W-1:0]   DZ_RESET     = 4'd0;
  localparam logic signed [V_W-1:0] V_RESET  = -7'sd1;

  localparam logic [KIND_W-1:0] EV_CLICK = 2'd0;
  localparam logic [KIND_W-1:0] EV_TOUCH = 2'd1;
  localparam logic [KIND_W-1:0] EV_POS   = 2'd2;
  localparam logic [KIND_W-1:0] EV_DIR   = 2'd3;

  localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd4;

  localparam logic signed [WGT_W-1:0] XW [16] = '{
    3'sd0, 3'sd0, -3'sd3, -3'sd3, 3'sd3, 3'sd3, 3'sd0, 3'sd0,
    3'sd0, 3'sd0, -3'sd3, -3'sd3, 3'sd3, 3'sd3, 3'sd0, 3'sd0
  };
  localparam logic [WGT_W-1:0] YW [16] = '{
    3'd0, 3'd0, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd4,
    3'd0, 3'd0, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd4
  };

  // control word field codes
  localparam logic [1:0] DIV_NONE = 2'd0;
  localparam logic [1:0] DIV_LD_X = 2'd1;
  localparam logic [1:0] DIV_LD_Y = 2'd2;
  localparam logic [1:0] DIV_STEP = 2'd3;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_DY   = 2'd1;
  localparam logic [1:0] ST_DX   = 2'd2;

  localparam logic [1:0] LAST_NO    = 2'd0;
  localparam logic [1:0] LAST_YES   = 2'd1;
  localparam logic [1:0] LAST_ZERO  = 2'd2;
  localparam logic [1:0] LAST_NOKEY = 2'd3;

  localparam logic [1:0] DSEL_NONE = 2'd0;
  localparam logic [1:0] DSEL_NEW  = 2'd1;
  localparam logic [1:0] DSEL_HELD = 2'd2;

  localparam logic [1:0] V_HOLD  = 2'd0;
  localparam logic [1:0] V_START = 2'd1;
  localparam logic [1:0] V_MOVE  = 2'd2;

  localparam logic [1:0] FD_HOLD = 2'd0;
  localparam logic [1:0] FD_SET  = 2'd1;
  localparam logic [1:0] FD_CLR  = 2'd2;

  localparam logic [1:0] KEY_HOLD = 2'd0;
  localparam logic [1:0] KEY_SET  = 2'd1;
  localparam logic [1:0] KEY_CLR  = 2'd2;
  localparam logic [1:0] KEY_WIPE = 2'd3;

  localparam logic [COND_W-1:0] C_NEVER       = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS      = 4'd1;
  localparam logic [COND_W-1:0] C_NO_IN       = 4'd2;
  localparam logic [COND_W-1:0] C_DISABLED    = 4'd3;
  localparam logic [COND_W-1:0] C_NO_CONTACT  = 4'd4;
  localparam logic [COND_W-1:0] C_DIV_BUSY    = 4'd5;
  localparam logic [COND_W-1:0] C_FINGER_DOWN = 4'd6;
  localparam logic [COND_W-1:0] C_ZERO_MOVE   = 4'd7;
  localparam logic [COND_W-1:0] C_NOT_EDGE    = 4'd8;
  localparam logic [COND_W-1:0] C_KEY_HELD    = 4'd9;
  localparam logic [COND_W-1:0] C_NOT_DOWN    = 4'd10;
  localparam logic [COND_W-1:0] C_NO_KEY      = 4'd11;

  localparam logic [PC_W-1:0] P_FETCH       = 5'd0;
  localparam logic [PC_W-1:0] P_CHK_EN      = 5'd1;
  localparam logic [PC_W-1:0] P_CHK_CONTACT = 5'd2;
  localparam logic [PC_W-1:0] P_LD_X        = 5'd3;
  localparam logic [PC_W-1:0] P_STEP_X      = 5'd4;
  localparam logic [PC_W-1:0] P_ST_DY       = 5'd5;
  localparam logic [PC_W-1:0] P_STEP_Y      = 5'd6;
  localparam logic [PC_W-1:0] P_ST_DX       = 5'd7;
  localparam logic [PC_W-1:0] P_FIRST_CLICK = 5'd8;
  localparam logic [PC_W-1:0] P_FIRST_TOUCH = 5'd9;
  localparam logic [PC_W-1:0] P_FIRST_POS   = 5'd10;
  localparam logic [PC_W-1:0] P_FIRST_POS2  = 5'd11;
  localparam logic [PC_W-1:0] P_LATER       = 5'd12;
  localparam logic [PC_W-1:0] P_EDGE_LIFT   = 5'd13;
  localparam logic [PC_W-1:0] P_EDGE_KEY    = 5'd14;
  localparam logic [PC_W-1:0] P_EDGE_TOUCH  = 5'd15;
  localparam logic [PC_W-1:0] P_MOVE        = 5'd16;
  localparam logic [PC_W-1:0] P_REPORT      = 5'd17;
  localparam logic [PC_W-1:0] P_REL_CHK     = 5'd18;
  localparam logic [PC_W-1:0] P_REL_CLICK   = 5'd19;
  localparam logic [PC_W-1:0] P_REL_TOUCH   = 5'd20;
  localparam logic [PC_W-1:0] P_REL_KEY     = 5'd21;
  localparam logic [PC_W-1:0] P_DISABLE     = 5'd22;

  typedef struct packed {
    logic              accept;
    logic [1:0]        div_op;
    logic [1:0]        st_op;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic              press;
    logic [1:0]        last_sel;
    logic [1:0]        dir_sel;
    logic              pos;
    logic [1:0]        virt_op;
    logic [1:0]        fd_op;
    logic [1:0]        key_op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ctrl_t;

  localparam ctrl_t CW_NOP = '{
    accept: 1'b0, div_op: DIV_NONE, st_op: ST_NONE, emit: 1'b0, kind: EV_CLICK,
    press: 1'b0, last_sel: LAST_NO, dir_sel: DSEL_NONE, pos: 1'b0, virt_op: V_HOLD,
    fd_op: FD_HOLD, key_op: KEY_HOLD, cond: C_NEVER, target: P_FETCH
  };

  function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = CW_NOP;
    unique case (pc)
      P_FETCH: begin
        w.accept = 1'b1;
        w.cond   = C_NO_IN;
        w.target = P_FETCH;
      end
      P_CHK_EN: begin
        w.cond   = C_DISABLED;
        w.target = P_DISABLE;
      end
      P_CHK_CONTACT: begin
        w.cond   = C_NO_CONTACT;
        w.target = P_REL_CHK;
      end
      P_LD_X: begin
        w.div_op = DIV_LD_X;
      end
      P_STEP_X: begin
        w.div_op = DIV_STEP;
        w.cond   = C_DIV_BUSY;
        w.target = P_STEP_X;
      end
      P_ST_DY: begin
        w.st_op  = ST_DY;
        w.div_op = DIV_LD_Y;
      end
      P_STEP_Y: begin
        w.div_op = DIV_STEP;
        w.cond   = C_DIV_BUSY;
        w.target = P_STEP_Y;
      end
      P_ST_DX: begin
        w.st_op  = ST_DX;
        w.cond   = C_FINGER_DOWN;
        w.target = P_LATER;
      end
      P_FIRST_CLICK: begin
        w.emit     = 1'b1;
        w.kind     = EV_CLICK;
        w.press    = 1'b1;
        w.last_sel = LAST_ZERO;
        w.fd_op    = FD_SET;
        w.cond     = C_ZERO_MOVE;
        w.target   = P_FETCH;
      end
      P_FIRST_TOUCH: begin
        w.emit    = 1'b1;
        w.kind    = EV_TOUCH;
        w.press   = 1'b1;
        w.virt_op = V_START;
      end
      P_FIRST_POS: begin
        w.emit    = 1'b1;
        w.kind    = EV_POS;
        w.pos     = 1'b1;
        w.virt_op = V_MOVE;
      end
      P_FIRST_POS2: begin
        w.emit     = 1'b1;
        w.kind     = EV_POS;
        w.pos      = 1'b1;
        w.last_sel = LAST_YES;
        w.cond     = C_ALWAYS;
        w.target   = P_FETCH;
      end
      P_LATER: begin
        w.cond   = C_NOT_EDGE;
        w.target = P_MOVE;
      end
      P_EDGE_LIFT: begin
        w.emit    = 1'b1;
        w.kind    = EV_TOUCH;
        w.virt_op = V_START;
        w.cond    = C_KEY_HELD;
        w.target  = P_EDGE_TOUCH;
      end
      P_EDGE_KEY: begin
        w.emit    = 1'b1;
        w.kind    = EV_DIR;
        w.press   = 1'b1;
        w.dir_sel = DSEL_NEW;
        w.key_op  = KEY_SET;
      end
      P_EDGE_TOUCH: begin
        w.emit   = 1'b1;
        w.kind   = EV_TOUCH;
        w.press  = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = P_REPORT;
      end
      P_MOVE: begin
        w.virt_op = V_MOVE;
      end
      P_REPORT: begin
        w.emit     = 1'b1;
        w.kind     = EV_POS;
        w.pos      = 1'b1;
        w.last_sel = LAST_YES;
        w.cond     = C_ALWAYS;
        w.target   = P_FETCH;
      end
      P_REL_CHK: begin
        w.cond   = C_NOT_DOWN;
        w.target = P_FETCH;
      end
      P_REL_CLICK: begin
        w.emit = 1'b1;
        w.kind = EV_CLICK;
      end
      P_REL_TOUCH: begin
        w.emit     = 1'b1;
        w.kind     = EV_TOUCH;
        w.last_sel = LAST_NOKEY;
        w.fd_op    = FD_CLR;
        w.cond     = C_NO_KEY;
        w.target   = P_FETCH;
      end
      P_REL_KEY: begin
        w.emit     = 1'b1;
        w.kind     = EV_DIR;
        w.dir_sel  = DSEL_HELD;
        w.last_sel = LAST_YES;
        w.key_op   = KEY_CLR;
        w.cond     = C_ALWAYS;
        w.target   = P_FETCH;
      end
      P_DISABLE: begin
        w.fd_op  = FD_CLR;
        w.key_op = KEY_WIPE;
        w.cond   = C_ALWAYS;
        w.target = P_FETCH;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = P_FETCH;
      end
    endcase
    return w;
  endfunction

  // 24*d/10 truncated toward zero, division by reciprocal
  function automatic logic signed [V_W-1:0] start_point(input logic signed [D_W-1:0] d);
    logic [D_W-1:0]       mag;
    logic [SP_PROD_W-1:0] prod;
    logic [V_W-1:0]       q;
    mag  = d[D_W-1] ? D_W'(-d) : D_W'(d);
    prod = SP_PROD_W'(mag) * SP_PROD_W'(SP_SCALE) * SP_PROD_W'(SP_RECIP);
    q    = V_W'(prod >> SP_SHIFT);
    return d[D_W-1] ? -signed'(q) : signed'(q);
  endfunction

  // ties go to the horizontal key
  function automatic logic [DIR_W-1:0] direction_of(input logic signed [D_W-1:0] x,
                                                    input logic signed [D_W-1:0] y);
    logic [D_W-1:0] ax;
    logic [D_W-1:0] ay;
    ax = x[D_W-1] ? D_W'(-x) : D_W'(x);
    ay = y[D_W-1] ? D_W'(-y) : D_W'(y);
    if (ay > ax) begin
      return y[D_W-1] ? DIR_UP : DIR_DOWN;
    end
    return x[D_W-1] ? DIR_LEFT : DIR_RIGHT;
  endfunction

endpackage

>>> design/stn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subzone touch navigator channels
// Valid/ready channels for the poll word and the event word.
// ----------------------------------------------------------------------------
interface stn_in_if;
  logic                           valid;
  logic                           ready;
  logic [stn_pkg::MASK_W-1:0]     finger_mask;

  modport source (output valid, output finger_mask, input ready);
  modport sink   (input valid, input finger_mask, output ready);
endinterface

interface stn_out_if;
  logic                              valid;
  logic                              ready;
  logic [stn_pkg::KIND_W-1:0]        event_kind;
  logic                              pressed;
  logic signed [stn_pkg::POS_W-1:0]  pos_x;
  logic signed [stn_pkg::POS_W-1:0]  pos_y;
  logic [stn_pkg::DIR_W-1:0]         direction;
  logic                              last;

  modport source (output valid, output event_kind, output pressed, output pos_x,
                  output pos_y, output direction, output last, input ready);
  modport sink   (input valid, input event_kind, input pressed, input pos_x,
                  input pos_y, input direction, input last, output ready);
endinterface

>>> design/stn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subzone touch navigator divider
// Restoring unsigned divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module stn_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   op,
  input  logic [stn_pkg::DNUM_W-1:0]   num,
  input  logic [stn_pkg::DDEN_W-1:0]   den,
  output logic [stn_pkg::DNUM_W-1:0]   quo,
  output logic                         busy
);

  logic [stn_pkg::DNUM_W-1:0] acc_r, acc_nxt;
  logic [stn_pkg::DDEN_W-1:0] rem_r, rem_nxt;
  logic [stn_pkg::DDEN_W-1:0] den_r, den_nxt;
  logic [stn_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [stn_pkg::DDEN_W:0]   trial;
  logic                       fits;

  assign trial = {rem_r, acc_r[stn_pkg::DNUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign quo   = acc_r;
  assign busy  = cnt_r != stn_pkg::DCNT_W'(stn_pkg::DIV_STEPS - 1);

  always_comb begin
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    unique case (op)
      stn_pkg::DIV_LD_X, stn_pkg::DIV_LD_Y: begin
        acc_nxt = num;
        rem_nxt = '0;
        den_nxt = den;
        cnt_nxt = '0;
      end
      stn_pkg::DIV_STEP: begin
        acc_nxt = {acc_r[stn_pkg::DNUM_W-2:0], fits};
        rem_nxt = fits ? stn_pkg::DDEN_W'(trial - {1'b0, den_r})
                       : trial[stn_pkg::DDEN_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

endmodule

>>> design/subzone_touch_navigator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subzone touch navigator
// Turns subzone coverage polls into click, touch, position and key events.
//
//   channel  | role  | word
//   in_ch    | sink  | finger_mask, one poll
//   out_ch   | source| event_kind, pressed, pos_x, pos_y, direction, last
//   cfg_*    | write | five registers by index, no read-back
//
// A poll walks the control store from acceptance to the next fetch: it
// takes the disable step when disabled, the release checks without
// contact, and with contact two 7-step divisions and one step per event.
// Synchronous active-low reset returns the step counter to fetch.
// A full event register with out_ch.ready low stalls the current step if it emits.
// ----------------------------------------------------------------------------
module subzone_touch_navigator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [stn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stn_pkg::CFG_DATA_W-1:0]     cfg_data,
  stn_in_if.sink                             in_ch,
  stn_out_if.source                          out_ch
);

  stn_pkg::ctrl_t cw;

  logic [stn_pkg::PC_W-1:0]          pc_r, pc_nxt;
  logic                              en_r, en_nxt;
  logic [stn_pkg::MASK_W-1:0]        corner_r, corner_nxt;
  logic [stn_pkg::EDGE_W-1:0]        edge_r, edge_nxt;
  logic [stn_pkg::DZ_W-1:0]          dzx_r, dzx_nxt;
  logic [stn_pkg::DZ_W-1:0]          dzy_r, dzy_nxt;
  logic                              fd_r, fd_nxt;
  logic                              key_r, key_nxt;
  logic [stn_pkg::DIR_W-1:0]         held_r, held_nxt;
  logic signed [stn_pkg::V_W-1:0]    vx_r, vx_nxt;
  logic signed [stn_pkg::V_W-1:0]    vy_r, vy_nxt;
  logic                              ov_r, ov_nxt;

  logic [stn_pkg::MASK_W-1:0]        mask_r, mask_nxt;
  logic signed [stn_pkg::D_W-1:0]    dx_r, dx_nxt;
  logic signed [stn_pkg::D_W-1:0]    dy_r, dy_nxt;
  logic                              neg_r, neg_nxt;
  logic [stn_pkg::KIND_W-1:0]        kind_r, kind_nxt;
  logic                              press_r, press_nxt;
  logic signed [stn_pkg::POS_W-1:0]  px_r, px_nxt;
  logic signed [stn_pkg::POS_W-1:0]  py_r, py_nxt;
  logic [stn_pkg::DIR_W-1:0]         dir_r, dir_nxt;
  logic                              last_r, last_nxt;

  logic [stn_pkg::NIB_W-1:0]         nib0, nib1, nib2;
  logic signed [stn_pkg::D_W-1:0]    xg, yg;
  logic [stn_pkg::NORM_W-1:0]        norm;
  logic [stn_pkg::D_W-1:0]           ax, ay;
  logic [stn_pkg::DNUM_W-1:0]        div_num;
  logic [stn_pkg::DDEN_W-1:0]        div_den;
  logic [stn_pkg::DNUM_W-1:0]        div_quo;
  logic                              div_busy;
  logic [stn_pkg::DZ_W-1:0]          dz;
  logic signed [stn_pkg::D_W-1:0]    d_store;
  logic signed [stn_pkg::V_W:0]      nx, ny, lim;
  logic                              contact, zero_move, at_edge;
  logic                              accept, stall, go, take;
  logic [stn_pkg::DIR_W-1:0]         new_dir;

  assign cw = stn_pkg::rom_word(pc_r);

  assign in_ch.ready = cw.accept;
  assign accept      = in_ch.valid && cw.accept;
  assign stall       = cw.emit && ov_r && !out_ch.ready;
  assign go          = !stall;

  // gravity from the three nibbles
  assign nib0 = mask_r[stn_pkg::NIB_W-1:0];
  assign nib1 = mask_r[2*stn_pkg::NIB_W-1:stn_pkg::NIB_W];
  assign nib2 = mask_r[3*stn_pkg::NIB_W-1:2*stn_pkg::NIB_W];
  assign xg   = stn_pkg::D_W'(stn_pkg::XW[nib0]) + stn_pkg::D_W'(stn_pkg::XW[nib1])
              + stn_pkg::D_W'(stn_pkg::XW[nib2]);
  assign yg   = signed'(stn_pkg::D_W'(stn_pkg::YW[nib0]))
              - signed'(stn_pkg::D_W'(stn_pkg::YW[nib2]));
  assign norm = stn_pkg::NORM_W'(stn_pkg::YW[nib0]) + stn_pkg::NORM_W'(stn_pkg::YW[nib1])
              + stn_pkg::NORM_W'(stn_pkg::YW[nib2]);
  assign ax   = xg[stn_pkg::D_W-1] ? stn_pkg::D_W'(-xg) : stn_pkg::D_W'(xg);
  assign ay   = yg[stn_pkg::D_W-1] ? stn_pkg::D_W'(-yg) : stn_pkg::D_W'(yg);

  always_comb begin
    if (cw.div_op == stn_pkg::DIV_LD_Y) begin
      div_num = stn_pkg::DNUM_W'(ay) * stn_pkg::DNUM_W'(stn_pkg::GRAV_SCALE);
      div_den = stn_pkg::DDEN_W'(norm);
    end else begin
      div_num = stn_pkg::DNUM_W'(ax) * stn_pkg::DNUM_W'(stn_pkg::GRAV_SCALE);
      div_den = stn_pkg::DDEN_W'(norm) * stn_pkg::DDEN_W'(stn_pkg::X_DIV);
    end
  end

  stn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (cw.div_op),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .busy  (div_busy)
  );

  // horizontal gravity feeds dy, vertical feeds dx
  assign dz = (cw.st_op == stn_pkg::ST_DY) ? dzx_r : dzy_r;

  always_comb begin
    if (norm == '0 || div_quo < stn_pkg::DNUM_W'(dz)) begin
      d_store = '0;
    end else if (neg_r) begin
      d_store = -signed'(stn_pkg::D_W'(div_quo));
    end else begin
      d_store = signed'(stn_pkg::D_W'(div_quo));
    end
  end

  assign contact   = |(mask_r & corner_r);
  assign zero_move = (dx_r == '0) && (dy_r == '0);
  assign nx        = (stn_pkg::V_W+1)'(vx_r) - (stn_pkg::V_W+1)'(dx_r);
  assign ny        = (stn_pkg::V_W+1)'(vy_r) - (stn_pkg::V_W+1)'(dy_r);
  assign lim       = signed'((stn_pkg::V_W+1)'(edge_r));
  assign at_edge   = (nx >= lim) || (nx <= -lim) || (ny >= lim) || (ny <= -lim);
  assign new_dir   = stn_pkg::direction_of(dx_r, dy_r);

  always_comb begin
    unique case (cw.cond)
      stn_pkg::C_NEVER:       take = 1'b0;
      stn_pkg::C_ALWAYS:      take = 1'b1;
      stn_pkg::C_NO_IN:       take = !in_ch.valid;
      stn_pkg::C_DISABLED:    take = !en_r;
      stn_pkg::C_NO_CONTACT:  take = !contact;
      stn_pkg::C_DIV_BUSY:    take = div_busy;
      stn_pkg::C_FINGER_DOWN: take = fd_r;
      stn_pkg::C_ZERO_MOVE:   take = zero_move;
      stn_pkg::C_NOT_EDGE:    take = !at_edge;
      stn_pkg::C_KEY_HELD:    take = key_r;
      stn_pkg::C_NOT_DOWN:    take = !fd_r;
      stn_pkg::C_NO_KEY:      take = !key_r;
      default:                take = 1'b0;
    endcase
  end

  // configuration writes
  always_comb begin
    en_nxt     = en_r;
    corner_nxt = corner_r;
    edge_nxt   = edge_r;
    dzx_nxt    = dzx_r;
    dzy_nxt    = dzy_r;
    if (cfg_we) begin
      unique case (cfg_index)
        stn_pkg::REG_NAV_ENABLE:  en_nxt     = cfg_data[0];
        stn_pkg::REG_CORNER_MASK: corner_nxt = cfg_data[stn_pkg::MASK_W-1:0];
        stn_pkg::REG_EDGE_LIMIT:  edge_nxt   = cfg_data[stn_pkg::EDGE_W-1:0];
        stn_pkg::REG_DEAD_ZONE_X: dzx_nxt    = cfg_data[stn_pkg::DZ_W-1:0];
        stn_pkg::REG_DEAD_ZONE_Y: dzy_nxt    = cfg_data[stn_pkg::DZ_W-1:0];
        default:                  en_nxt     = en_r;
      endcase
    end
  end

  // sequencer datapath
  always_comb begin
    pc_nxt    = pc_r;
    fd_nxt    = fd_r;
    key_nxt   = key_r;
    held_nxt  = held_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    ov_nxt    = ov_r;
    mask_nxt  = accept ? in_ch.finger_mask : mask_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    neg_nxt   = neg_r;
    kind_nxt  = kind_r;
    press_nxt = press_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    dir_nxt   = dir_r;
    last_nxt  = last_r;

    if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    if (go) begin
      pc_nxt = take ? cw.target : pc_r + 1'b1;

      if (cw.div_op == stn_pkg::DIV_LD_X) begin
        neg_nxt = xg[stn_pkg::D_W-1];
      end else if (cw.div_op == stn_pkg::DIV_LD_Y) begin
        neg_nxt = yg[stn_pkg::D_W-1];
      end

      unique case (cw.st_op)
        stn_pkg::ST_DY: dy_nxt = d_store;
        stn_pkg::ST_DX: dx_nxt = d_store;
        default:        dx_nxt = dx_r;
      endcase

      unique case (cw.fd_op)
        stn_pkg::FD_SET: fd_nxt = 1'b1;
        stn_pkg::FD_CLR: fd_nxt = 1'b0;
        default:         fd_nxt = fd_r;
      endcase

      unique case (cw.key_op)
        stn_pkg::KEY_SET: begin
          key_nxt  = 1'b1;
          held_nxt = new_dir;
        end
        stn_pkg::KEY_CLR: key_nxt = 1'b0;
        stn_pkg::KEY_WIPE: begin
          key_nxt  = 1'b0;
          held_nxt = stn_pkg::DIR_NONE;
        end
        default: key_nxt = key_r;
      endcase

      unique case (cw.virt_op)
        stn_pkg::V_START: begin
          vx_nxt = stn_pkg::start_point(dx_r);
          vy_nxt = stn_pkg::start_point(dy_r);
        end
        stn_pkg::V_MOVE: begin
          vx_nxt = nx[stn_pkg::V_W-1:0];
          vy_nxt = ny[stn_pkg::V_W-1:0];
        end
        default: vx_nxt = vx_r;
      endcase

      if (cw.emit) begin
        ov_nxt    = 1'b1;
        kind_nxt  = cw.kind;
        press_nxt = cw.press;
        px_nxt    = cw.pos ? vx_r[stn_pkg::POS_W-1:0] : '0;
        py_nxt    = cw.pos ? vy_r[stn_pkg::POS_W-1:0] : '0;
        unique case (cw.dir_sel)
          stn_pkg::DSEL_NEW:  dir_nxt = new_dir;
          stn_pkg::DSEL_HELD: dir_nxt = held_r;
          default:            dir_nxt = stn_pkg::DIR_NONE;
        endcase
        unique case (cw.last_sel)
          stn_pkg::LAST_YES:   last_nxt = 1'b1;
          stn_pkg::LAST_ZERO:  last_nxt = zero_move;
          stn_pkg::LAST_NOKEY: last_nxt = !key_r;
          default:             last_nxt = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= stn_pkg::P_FETCH;
      en_r     <= stn_pkg::EN_RESET;
      corner_r <= stn_pkg::CORNER_RESET;
      edge_r   <= stn_pkg::EDGE_RESET;
      dzx_r    <= stn_pkg::DZ_RESET;
      dzy_r    <= stn_pkg::DZ_RESET;
      fd_r     <= 1'b0;
      key_r    <= 1'b0;
      held_r   <= stn_pkg::DIR_NONE;
      vx_r     <= stn_pkg::V_RESET;
      vy_r     <= stn_pkg::V_RESET;
      ov_r     <= 1'b0;
    end else begin
      pc_r     <= pc_nxt;
      en_r     <= en_nxt;
      corner_r <= corner_nxt;
      edge_r   <= edge_nxt;
      dzx_r    <= dzx_nxt;
      dzy_r    <= dzy_nxt;
      fd_r     <= fd_nxt;
      key_r    <= key_nxt;
      held_r   <= held_nxt;
      vx_r     <= vx_nxt;
      vy_r     <= vy_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r  <= mask_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    neg_r   <= neg_nxt;
    kind_r  <= kind_nxt;
    press_r <= press_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    dir_r   <= dir_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.event_kind = kind_r;
  assign out_ch.pressed    = press_r;
  assign out_ch.pos_x      = px_r;
  assign out_ch.pos_y      = py_r;
  assign out_ch.direction  = dir_r;
  assign out_ch.last       = last_r;

endmodule
